// ===== hw/rtl/sbcd_pkg.sv =====
package sbcd_pkg;

    localparam int CODES_PER_WORD = 8;
    localparam logic [6:0] MAX_CELLS = 7'd64;
    localparam logic [30:0] ROW_MAX = 31'h7FFF_FFFF;
    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] SPACES_BITS = 64'h2020_2020_2020_2020;

    localparam logic [7:0] CODE_SKIP = 8'd0;
    localparam logic [7:0] CODE_END = 8'd252;
    localparam logic [7:0] CODE_RAW = 8'd253;
    localparam logic [7:0] CODE_SPACES = 8'd254;
    localparam logic [7:0] CODE_MISSING = 8'd255;

    localparam logic [2:0] REG_COMPRESSED = 3'd0;
    localparam logic [2:0] REG_SWAP = 3'd1;
    localparam logic [2:0] REG_CELLS_PER_ROW = 3'd2;
    localparam logic [2:0] REG_STRING_MASK = 3'd3;
    localparam logic [2:0] REG_EXPECTED_ROWS = 3'd4;

    typedef enum logic [2:0] {
        ST_NUMBER   = 3'd0,
        ST_STRING   = 3'd1,
        ST_MISSING  = 3'd2,
        ST_END      = 3'd3,
        ST_ROWS_OK  = 3'd4,
        ST_ROWS_BAD = 3'd5,
        ST_BAD_CODE = 3'd6,
        ST_HALTED   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_HALTED,
        OP_EOF,
        OP_PASS,
        OP_RAW,
        OP_LOAD,
        OP_STEP
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic halted;
        logic compressed;
        logic awaiting;
        logic pending;
        logic step_done;
    } dp_status_t;

    function automatic logic [63:0] reverse_bytes(input logic [63:0] w);
        logic [63:0] r;
        for (int k = 0; k < 8; k++)
        begin
            r[8*k +: 8] = w[8*(7-k) +: 8];
        end
        return r;
    endfunction

    // IEEE double bits of (code - 100) for codes 1 to 251.
    function automatic logic [63:0] small_int_bits(input logic [7:0] code);
        logic [8:0] v;
        logic [8:0] absv;
        logic [7:0] mag;
        logic [7:0] norm;
        logic [2:0] e;
        logic neg;
        v = {1'b0, code} - 9'd100;
        neg = v[8];
        absv = neg ? (9'd0 - v) : v;
        mag = absv[7:0];
        e = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (mag[i])
            begin
                e = 3'(i);
            end
        end
        norm = mag << (3'd7 - e);
        if (mag == 8'd0)
        begin
            return 64'd0;
        end
        return {neg, 11'd1023 + {8'd0, e}, norm[6:0], 45'd0};
    endfunction

    // True when a code at or after start yields a result before any raw-cell code.
    function automatic logic more_results(input logic [63:0] cw, input logic [3:0] start);
        logic found;
        logic more;
        found = 1'b0;
        more = 1'b0;
        for (int j = 0; j < CODES_PER_WORD; j++)
        begin
            if (!found && (4'(j) >= start) && (cw[8*j +: 8] != CODE_SKIP))
            begin
                found = 1'b1;
                more = (cw[8*j +: 8] != CODE_RAW);
            end
        end
        return more;
    endfunction

endpackage

// ===== hw/rtl/sbcd_if.sv =====
interface sbcd_word_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] word;

    modport source (output valid, output kind, output word, input ready);
    modport sink (input valid, input kind, input word, output ready);
endinterface

interface sbcd_cell_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] cell_value;
    logic [5:0]  cell_position;
    logic [30:0] row_number;
    logic        last;

    modport source (output valid, output status, output cell_value, output cell_position,
                    output row_number, output last, input ready);
    modport sink (input valid, input status, input cell_value, input cell_position,
                  input row_number, input last, output ready);
endinterface

// ===== hw/rtl/sav_bytecode_cell_decoder_top.sv =====
// A control word is loaded and then stepped through code by code, with at most one result
// per cycle; a raw word is taken and any codes still pending after it are then stepped,
// and an end of file, a halted reply or an uncompressed word yields a single result.
// Each result is registered in the cycle after it is decoded; steps hold while a result waits.
// Reset is asynchronous and active low; it restores the register defaults, clears the
// decoder state and leaves no result pending.
module sav_bytecode_cell_decoder_top #(
    parameter logic [6:0] MAX_CELLS = sbcd_pkg::MAX_CELLS
) (
    input  logic         clk,
    input  logic         rst_n,
    sbcd_word_if.sink    words,
    sbcd_cell_if.source  cells,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    sbcd_pkg::dp_cmd_t    cmd;
    sbcd_pkg::dp_status_t st;
    logic                 in_ready;

    sbcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (words.valid),
        .in_kind  (words.kind),
        .st       (st),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    sbcd_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_word      (words.word),
        .out_ready    (cells.ready),
        .out_valid    (cells.valid),
        .out_status   (cells.status),
        .out_value    (cells.cell_value),
        .out_position (cells.cell_position),
        .out_row      (cells.row_number),
        .out_last     (cells.last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    assign words.ready = in_ready;

endmodule

// ===== hw/rtl/sbcd_ctrl.sv =====
module sbcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_kind,
    input  sbcd_pkg::dp_status_t  st,
    output logic                  in_ready,
    output sbcd_pkg::dp_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_DECODE = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op = sbcd_pkg::OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = st.slot_free;
                if (in_valid && st.slot_free)
                begin
                    if (st.halted)
                    begin
                        cmd.op = sbcd_pkg::OP_HALTED;
                    end
                    else if (in_kind)
                    begin
                        cmd.op = sbcd_pkg::OP_EOF;
                    end
                    else if (!st.compressed)
                    begin
                        cmd.op = sbcd_pkg::OP_PASS;
                    end
                    else if (st.awaiting)
                    begin
                        cmd.op = sbcd_pkg::OP_RAW;
                        if (st.pending)
                        begin
                            state_next = S_DECODE;
                        end
                    end
                    else if (!st.pending)
                    begin
                        cmd.op = sbcd_pkg::OP_LOAD;
                        state_next = S_DECODE;
                    end
                    else
                    begin
                        state_next = S_DECODE;
                    end
                end
            end
            S_DECODE:
            begin
                if (st.slot_free)
                begin
                    cmd.op = sbcd_pkg::OP_STEP;
                    if (st.step_done)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/sbcd_dp.sv =====
module sbcd_dp #(
    parameter logic [6:0] MAX_CELLS = sbcd_pkg::MAX_CELLS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sbcd_pkg::dp_cmd_t     cmd,
    output sbcd_pkg::dp_status_t  st,
    input  logic [63:0]           in_word,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [2:0]            out_status,
    output logic [63:0]           out_value,
    output logic [5:0]            out_position,
    output logic [30:0]           out_row,
    output logic                  out_last,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    logic        compressed_reg;
    logic        swap_reg;
    logic [6:0]  cells_per_row_reg;
    logic [63:0] mask_reg;
    logic [30:0] expected_reg;

    logic [63:0] control_word_reg, control_word_next;
    logic [3:0]  code_pos_reg, code_pos_next;
    logic        awaiting_reg, awaiting_next;
    logic [5:0]  cell_reg, cell_next;
    logic [30:0] row_reg, row_next;
    logic        halted_reg, halted_next;

    logic        out_valid_reg, out_valid_next;
    sbcd_pkg::status_t out_status_reg;
    logic [63:0] out_value_reg;
    logic [5:0]  out_pos_reg;
    logic [30:0] out_row_reg;
    logic        out_last_reg;

    logic        slot_free;
    logic [7:0]  code;
    logic        is_string;
    logic [6:0]  row_limit;
    logic [5:0]  cell_inc;
    logic        wrap;
    logic [3:0]  pos_inc;
    logic [63:0] raw_value;
    sbcd_pkg::status_t raw_status;

    logic        emit;
    logic        advance;
    sbcd_pkg::status_t e_status;
    logic [63:0] e_value;
    logic        e_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign code = control_word_reg[8*code_pos_reg[2:0] +: 8];
    assign is_string = mask_reg[cell_reg];
    assign cell_inc = cell_reg + 6'd1;
    assign pos_inc = code_pos_reg + 4'd1;

    always_comb
    begin
        if (cells_per_row_reg == 7'd0)
        begin
            row_limit = 7'd1;
        end
        else if (cells_per_row_reg > MAX_CELLS)
        begin
            row_limit = MAX_CELLS;
        end
        else
        begin
            row_limit = cells_per_row_reg;
        end
    end

    assign wrap = ({1'b0, cell_inc} >= row_limit) || (cell_inc == 6'd0);

    always_comb
    begin
        if (is_string)
        begin
            raw_status = sbcd_pkg::ST_STRING;
            raw_value = in_word;
        end
        else
        begin
            raw_status = sbcd_pkg::ST_NUMBER;
            raw_value = swap_reg ? sbcd_pkg::reverse_bytes(in_word) : in_word;
        end
    end

    always_comb
    begin
        st.slot_free = slot_free;
        st.halted = halted_reg;
        st.compressed = compressed_reg;
        st.awaiting = awaiting_reg;
        st.pending = code_pos_reg < 4'(sbcd_pkg::CODES_PER_WORD);
        st.step_done = (code == sbcd_pkg::CODE_RAW) || (code == sbcd_pkg::CODE_END)
                       || ((code == sbcd_pkg::CODE_SPACES) && !is_string)
                       || (code_pos_reg == 4'(sbcd_pkg::CODES_PER_WORD - 1));
    end

    always_comb
    begin
        control_word_next = control_word_reg;
        code_pos_next = code_pos_reg;
        awaiting_next = awaiting_reg;
        halted_next = halted_reg;
        emit = 1'b0;
        advance = 1'b0;
        e_status = sbcd_pkg::ST_NUMBER;
        e_value = 64'd0;
        e_last = 1'b1;
        unique case (cmd.op)
            sbcd_pkg::OP_NONE:
            begin
            end
            sbcd_pkg::OP_HALTED:
            begin
                emit = 1'b1;
                e_status = sbcd_pkg::ST_HALTED;
            end
            sbcd_pkg::OP_EOF:
            begin
                emit = 1'b1;
                halted_next = 1'b1;
                if (compressed_reg && awaiting_reg)
                begin
                    e_status = sbcd_pkg::ST_BAD_CODE;
                end
                else if (row_reg == expected_reg)
                begin
                    e_status = sbcd_pkg::ST_ROWS_OK;
                end
                else
                begin
                    e_status = sbcd_pkg::ST_ROWS_BAD;
                end
            end
            sbcd_pkg::OP_PASS:
            begin
                emit = 1'b1;
                advance = 1'b1;
                e_status = raw_status;
                e_value = raw_value;
            end
            sbcd_pkg::OP_RAW:
            begin
                emit = 1'b1;
                advance = 1'b1;
                awaiting_next = 1'b0;
                e_status = raw_status;
                e_value = raw_value;
                e_last = !sbcd_pkg::more_results(control_word_reg, code_pos_reg);
            end
            sbcd_pkg::OP_LOAD:
            begin
                control_word_next = in_word;
                code_pos_next = 4'd0;
            end
            sbcd_pkg::OP_STEP:
            begin
                code_pos_next = pos_inc;
                e_last = !sbcd_pkg::more_results(control_word_reg, pos_inc);
                unique case (code)
                    sbcd_pkg::CODE_SKIP:
                    begin
                    end
                    sbcd_pkg::CODE_END:
                    begin
                        emit = 1'b1;
                        e_status = sbcd_pkg::ST_END;
                        e_last = 1'b1;
                        halted_next = 1'b1;
                        code_pos_next = 4'(sbcd_pkg::CODES_PER_WORD);
                    end
                    sbcd_pkg::CODE_RAW:
                    begin
                        awaiting_next = 1'b1;
                    end
                    sbcd_pkg::CODE_SPACES:
                    begin
                        emit = 1'b1;
                        if (is_string)
                        begin
                            advance = 1'b1;
                            e_status = sbcd_pkg::ST_STRING;
                            e_value = sbcd_pkg::SPACES_BITS;
                        end
                        else
                        begin
                            e_status = sbcd_pkg::ST_BAD_CODE;
                            e_last = 1'b1;
                            halted_next = 1'b1;
                            code_pos_next = 4'(sbcd_pkg::CODES_PER_WORD);
                        end
                    end
                    sbcd_pkg::CODE_MISSING:
                    begin
                        emit = 1'b1;
                        advance = 1'b1;
                        e_status = sbcd_pkg::ST_MISSING;
                        e_value = sbcd_pkg::QNAN_BITS;
                    end
                    default:
                    begin
                        emit = 1'b1;
                        advance = 1'b1;
                        e_status = sbcd_pkg::ST_NUMBER;
                        e_value = sbcd_pkg::small_int_bits(code);
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        cell_next = cell_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (wrap)
            begin
                cell_next = 6'd0;
                if (row_reg != sbcd_pkg::ROW_MAX)
                begin
                    row_next = row_reg + 31'd1;
                end
            end
            else
            begin
                cell_next = cell_inc;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compressed_reg <= 1'b1;
            swap_reg <= 1'b0;
            cells_per_row_reg <= 7'd1;
            mask_reg <= 64'd0;
            expected_reg <= 31'd0;
            control_word_reg <= 64'd0;
            code_pos_reg <= 4'(sbcd_pkg::CODES_PER_WORD);
            awaiting_reg <= 1'b0;
            cell_reg <= 6'd0;
            row_reg <= 31'd0;
            halted_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            control_word_reg <= control_word_next;
            code_pos_reg <= code_pos_next;
            awaiting_reg <= awaiting_next;
            cell_reg <= cell_next;
            row_reg <= row_next;
            halted_reg <= halted_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sbcd_pkg::REG_COMPRESSED:    compressed_reg <= cfg_data[0];
                    sbcd_pkg::REG_SWAP:          swap_reg <= cfg_data[0];
                    sbcd_pkg::REG_CELLS_PER_ROW: cells_per_row_reg <= cfg_data[6:0];
                    sbcd_pkg::REG_STRING_MASK:   mask_reg <= cfg_data;
                    sbcd_pkg::REG_EXPECTED_ROWS: expected_reg <= cfg_data[30:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= e_status;
            out_value_reg <= e_value;
            out_pos_reg <= cell_reg;
            out_row_reg <= row_reg;
            out_last_reg <= e_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value = out_value_reg;
    assign out_position = out_pos_reg;
    assign out_row = out_row_reg;
    assign out_last = out_last_reg;

endmodule

// ===== hw/rtl/sbcd_chk.sv =====
module sbcd_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [63:0] cell_value,
    input logic        last
);

    logic seen_halt_reg;
    logic halting;

    assign halting = (status == sbcd_pkg::ST_END) || (status == sbcd_pkg::ST_ROWS_OK)
                     || (status == sbcd_pkg::ST_ROWS_BAD) || (status == sbcd_pkg::ST_BAD_CODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
        end
        else if (out_valid && out_ready && halting)
        begin
            seen_halt_reg <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(cell_value)
        && $stable(last))
        else $error("result changed while stalled");

    a_halting_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (halting || status == sbcd_pkg::ST_HALTED) |-> last)
        else $error("halting result not marked last");

    a_after_halt: assert property (@(posedge clk) disable iff (!rst_n)
        seen_halt_reg && out_valid |-> status == sbcd_pkg::ST_HALTED)
        else $error("decoded result after the block halted");

    a_halted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (halting || status == sbcd_pkg::ST_HALTED) |-> cell_value == 64'd0)
        else $error("halting result carries a cell value");

endmodule

bind sav_bytecode_cell_decoder_top sbcd_chk u_sbcd_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (cells.valid),
    .out_ready  (cells.ready),
    .status     (cells.status),
    .cell_value (cells.cell_value),
    .last       (cells.last)
);

// ===== bench/tb_sav_bytecode_cell_decoder_top.sv =====
module tb_sav_bytecode_cell_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        sbcd_pkg::status_t status;
        logic [63:0]       value;
        logic [5:0]        position;
        logic [30:0]       row;
        logic              last;
    } cell_result_t;

    typedef struct {
        logic        compressed;
        logic        swap;
        logic [6:0]  row_cells;
        logic [63:0] string_mask;
        logic [30:0] expected_rows;
        logic [63:0] control;
        logic [3:0]  code_pos;
        logic        awaiting;
        logic [5:0]  cur_cell;
        logic [30:0] rows;
        logic        halted;
    } decoder_state_t;

    typedef enum int {
        STOP_ROWS_OK,
        STOP_ROWS_BAD,
        STOP_END_CODE,
        STOP_SPACES_NUMERIC,
        STOP_EOF_AWAITING
    } stop_case_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    sbcd_word_if words_ch ();
    sbcd_cell_if cells_ch ();

    decoder_state_t decoder;
    cell_result_t   decoded [0:8];
    cell_result_t   pending_cells [$];
    cell_result_t   oldest;
    int             failures = 0;
    int             words_sent = 0;
    int             idle_cycles = 0;
    int             ready_wait;
    bit             send_gaps = 1'b1;
    bit             take_stalls = 1'b1;

    sav_bytecode_cell_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .words     (words_ch),
        .cells     (cells_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void emit_cell(inout decoder_state_t s, inout int n,
                                      input sbcd_pkg::status_t status,
                                      input logic [63:0] value, input bit advance);
        int row_len;
        decoded[n].status = status;
        decoded[n].value = value;
        decoded[n].position = s.cur_cell;
        decoded[n].row = s.rows;
        decoded[n].last = 1'b0;
        n++;
        if (advance)
        begin
            if (s.row_cells == 7'd0)
                row_len = 1;
            else if (s.row_cells > sbcd_pkg::MAX_CELLS)
                row_len = int'(sbcd_pkg::MAX_CELLS);
            else
                row_len = int'(s.row_cells);
            s.cur_cell = s.cur_cell + 6'd1;
            if (s.cur_cell >= row_len || s.cur_cell == 6'd0)
            begin
                s.cur_cell = 6'd0;
                if (s.rows != sbcd_pkg::ROW_MAX)
                    s.rows = s.rows + 31'd1;
            end
        end
    endfunction

    function automatic void emit_raw(inout decoder_state_t s, inout int n,
                                     input logic [63:0] w);
        logic [63:0] flipped;
        for (int k = 0; k < 8; k++)
            flipped[8*k +: 8] = w[56 - 8*k +: 8];
        if (s.string_mask[s.cur_cell])
            emit_cell(s, n, sbcd_pkg::ST_STRING, w, 1'b1);
        else
            emit_cell(s, n, sbcd_pkg::ST_NUMBER, s.swap ? flipped : w, 1'b1);
    endfunction

    function automatic int decode_item(inout decoder_state_t s, input logic kind,
                                       input logic [63:0] w);
        int          n;
        int          delta;
        int          magnitude;
        int          msb;
        logic [63:0] mantissa;
        logic [7:0]  code;
        bit          wait_raw;
        n = 0;
        wait_raw = 1'b0;
        if (s.halted)
            emit_cell(s, n, sbcd_pkg::ST_HALTED, 64'd0, 1'b0);
        else if (kind)
        begin
            if (s.compressed && s.awaiting)
                emit_cell(s, n, sbcd_pkg::ST_BAD_CODE, 64'd0, 1'b0);
            else
                emit_cell(s, n, (s.rows == s.expected_rows) ? sbcd_pkg::ST_ROWS_OK :
                          sbcd_pkg::ST_ROWS_BAD, 64'd0, 1'b0);
            s.halted = 1'b1;
        end
        else if (!s.compressed)
            emit_raw(s, n, w);
        else
        begin
            if (s.awaiting)
            begin
                emit_raw(s, n, w);
                s.awaiting = 1'b0;
            end
            else if (s.code_pos >= 4'd8)
            begin
                s.control = w;
                s.code_pos = 4'd0;
            end
            while (s.code_pos < 4'd8 && !s.halted && !wait_raw)
            begin
                code = s.control[8*s.code_pos +: 8];
                s.code_pos = s.code_pos + 4'd1;
                case (code)
                    sbcd_pkg::CODE_SKIP: ;
                    sbcd_pkg::CODE_END:
                    begin
                        emit_cell(s, n, sbcd_pkg::ST_END, 64'd0, 1'b0);
                        s.halted = 1'b1;
                    end
                    sbcd_pkg::CODE_RAW:
                    begin
                        s.awaiting = 1'b1;
                        wait_raw = 1'b1;
                    end
                    sbcd_pkg::CODE_SPACES:
                    begin
                        if (s.string_mask[s.cur_cell])
                            emit_cell(s, n, sbcd_pkg::ST_STRING, sbcd_pkg::SPACES_BITS,
                                      1'b1);
                        else
                        begin
                            emit_cell(s, n, sbcd_pkg::ST_BAD_CODE, 64'd0, 1'b0);
                            s.halted = 1'b1;
                        end
                    end
                    sbcd_pkg::CODE_MISSING:
                        emit_cell(s, n, sbcd_pkg::ST_MISSING, sbcd_pkg::QNAN_BITS, 1'b1);
                    default:
                    begin
                        delta = int'(code) - 100;
                        magnitude = (delta < 0) ? -delta : delta;
                        msb = 0;
                        while ((magnitude >> (msb + 1)) != 0)
                            msb++;
                        mantissa = 64'(magnitude) << (52 - msb);
                        emit_cell(s, n, sbcd_pkg::ST_NUMBER, (delta == 0) ? 64'd0 :
                                  {delta < 0, 11'(1023 + msb), mantissa[51:0]}, 1'b1);
                    end
                endcase
            end
            if (s.halted)
                s.code_pos = 4'd8;
        end
        if (n > 0)
            decoded[n-1].last = 1'b1;
        return n;
    endfunction

    task automatic send_word(input logic kind, input logic [63:0] w);
        int gap;
        int count;
        gap = send_gaps ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            words_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // The request stays up until the decoder takes it.
        words_ch.valid <= 1'b1;
        words_ch.kind <= kind;
        words_ch.word <= w;
        do
            @(posedge clk);
        while (words_ch.ready !== 1'b1);
        count = decode_item(decoder, kind, w);
        for (int i = 0; i < count; i++)
            pending_cells.push_back(decoded[i]);
        words_sent++;
    endtask

    task automatic wait_results();
        words_ch.valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        case (index)
            sbcd_pkg::REG_COMPRESSED: decoder.compressed = data[0];
            sbcd_pkg::REG_SWAP: decoder.swap = data[0];
            sbcd_pkg::REG_CELLS_PER_ROW: decoder.row_cells = data[6:0];
            sbcd_pkg::REG_STRING_MASK: decoder.string_mask = data;
            sbcd_pkg::REG_EXPECTED_ROWS: decoder.expected_rows = data[30:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic compressed, input logic swap,
                              input logic [6:0] row_cells, input logic [63:0] string_mask,
                              input logic [30:0] expected_rows);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(sbcd_pkg::REG_COMPRESSED, {63'd0, compressed});
        write_reg(sbcd_pkg::REG_SWAP, {63'd0, swap});
        write_reg(sbcd_pkg::REG_CELLS_PER_ROW, {57'd0, row_cells});
        write_reg(sbcd_pkg::REG_STRING_MASK, string_mask);
        write_reg(sbcd_pkg::REG_EXPECTED_ROWS, {33'd0, expected_rows});
        cfg_we <= 1'b0;
    endtask

    task automatic test_numeric_and_missing_codes();
        send_word(1'b0, {8'd99, 8'd101, 8'd0, sbcd_pkg::CODE_MISSING, 8'd0, 8'd251, 8'd100,
                         8'd1});
        send_word(1'b0, 64'd0);
        send_word(1'b0, {8{8'd228}});
    endtask

    task automatic test_raw_and_space_codes();
        set_config(1'b1, 1'b1, 7'd3, 64'h5, 31'h7FFF_FFFF);
        send_word(1'b0, {8'd0, 8'd0, sbcd_pkg::CODE_SPACES, sbcd_pkg::CODE_MISSING, 8'd150,
                         sbcd_pkg::CODE_RAW, sbcd_pkg::CODE_RAW, sbcd_pkg::CODE_SPACES});
        send_word(1'b0, 64'h0123_4567_89AB_CDEF);
        send_word(1'b0, 64'hFEDC_BA98_7654_3210);
        send_word(1'b0, {sbcd_pkg::CODE_RAW, 56'd0});
        send_word(1'b0, '1);
        send_word(1'b0, {8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, sbcd_pkg::CODE_RAW});
        send_word(1'b0, 64'h8000_0000_0000_0001);
        set_config(1'b1, 1'b0, 7'd0, '1, 31'd0);
        send_word(1'b0, {8{sbcd_pkg::CODE_SPACES}});
        send_word(1'b0, {8{sbcd_pkg::CODE_MISSING}});
    endtask

    task automatic test_uncompressed_cells();
        set_config(1'b0, 1'b1, 7'd64, 64'hAAAA_AAAA_AAAA_AAAA, 31'd0);
        send_word(1'b0, 64'd0);
        send_word(1'b0, '1);
        send_word(1'b0, 64'h0123_4567_89AB_CDEF);
        send_word(1'b0, 64'h8000_0000_0000_0001);
        set_config(1'b0, 1'b0, 7'd127, 64'h0F0F_0F0F_0F0F_0F0F, 31'd0);
        send_word(1'b0, 64'h0123_4567_89AB_CDEF);
        send_word(1'b0, random_word());
    endtask

    task automatic test_mode_switch_with_pending_codes();
        set_config(1'b1, 1'b0, 7'd2, 64'd0, 31'd0);
        send_word(1'b0, {40'd0, 8'd95, 8'd105, sbcd_pkg::CODE_RAW});
        set_config(1'b0, 1'b0, 7'd2, 64'd0, 31'd0);
        send_word(1'b0, random_word());
        send_word(1'b0, random_word());
        set_config(1'b1, 1'b0, 7'd2, 64'd0, 31'd0);
        send_word(1'b0, random_word());
    endtask

    task automatic test_random_streams();
        logic [6:0]     row_cells;
        logic [63:0]    string_mask;
        logic [30:0]    expected_rows;
        logic [63:0]    control;
        logic [63:0]    raw_words [0:7];
        logic [7:0]     code;
        decoder_state_t trial;
        int             raw_count;
        int             tries;
        int             target;
        for (int phase = 0; phase < 7; phase++)
        begin
            case ($urandom_range(0, 5))
                0: row_cells = 7'd0;
                1: row_cells = 7'd1;
                2: row_cells = 7'd64;
                3: row_cells = 7'd127;
                4: row_cells = 7'd65;
                default: row_cells = 7'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 3))
                0: string_mask = 64'd0;
                1: string_mask = '1;
                2: string_mask = {$urandom, $urandom};
                default: string_mask = 64'h5555_5555_5555_5555 << $urandom_range(0, 1);
            endcase
            case ($urandom_range(0, 2))
                0: expected_rows = 31'd0;
                1: expected_rows = 31'h7FFF_FFFF;
                default: expected_rows = 31'($urandom);
            endcase
            set_config((phase != 3) && ($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)),
                       row_cells, string_mask, expected_rows);
            send_gaps = (phase != 1) && ($urandom_range(0, 4) != 0);
            take_stalls = (phase != 1) && ($urandom_range(0, 4) != 0);
            target = words_sent + 60;
            while (words_sent < target)
            begin
                if ($urandom_range(0, 24) == 0)
                    wait_results();
                if (!decoder.compressed)
                    send_word(1'b0, random_word());
                else
                begin
                    tries = 0;
                    do
                    begin
                        control = 64'd0;
                        raw_count = 0;
                        if ($urandom_range(0, 24) != 0)
                        begin
                            for (int k = 0; k < 8; k++)
                            begin
                                case ($urandom_range(0, 9))
                                    0, 1: code = sbcd_pkg::CODE_SKIP;
                                    2: code = sbcd_pkg::CODE_RAW;
                                    3: code = (tries < 20) ? sbcd_pkg::CODE_SPACES :
                                              sbcd_pkg::CODE_MISSING;
                                    4: code = sbcd_pkg::CODE_MISSING;
                                    default: code = 8'($urandom_range(1, 251));
                                endcase
                                control[8*k +: 8] = code;
                                if (code == sbcd_pkg::CODE_RAW)
                                    raw_count++;
                            end
                        end
                        for (int k = 0; k < raw_count; k++)
                            raw_words[k] = random_word();
                        trial = decoder;
                        void'(decode_item(trial, 1'b0, control));
                        for (int k = 0; k < raw_count; k++)
                            void'(decode_item(trial, 1'b0, raw_words[k]));
                        tries++;
                    end
                    while (trial.halted);
                    send_word(1'b0, control);
                    for (int k = 0; k < raw_count; k++)
                        send_word(1'b0, raw_words[k]);
                end
            end
        end
        send_gaps = 1'b1;
        take_stalls = 1'b1;
    endtask

    task automatic test_stop_condition();
        stop_case_t pick;
        pick = stop_case_t'($urandom_range(0, 4));
        case (pick)
            STOP_ROWS_OK:
            begin
                set_config(decoder.compressed, decoder.swap, decoder.row_cells,
                           decoder.string_mask, decoder.rows);
                send_word(1'b1, random_word());
            end
            STOP_ROWS_BAD:
            begin
                set_config(decoder.compressed, decoder.swap, decoder.row_cells,
                           decoder.string_mask, decoder.rows + 31'd1);
                send_word(1'b1, random_word());
            end
            STOP_END_CODE:
            begin
                set_config(1'b1, decoder.swap, decoder.row_cells, decoder.string_mask,
                           decoder.expected_rows);
                send_word(1'b0, 64'hFF00_FE01_01FD_FC65);
            end
            STOP_SPACES_NUMERIC:
            begin
                set_config(1'b1, decoder.swap, decoder.row_cells, 64'd0,
                           decoder.expected_rows);
                send_word(1'b0, 64'h6565_6565_65FE_6566);
            end
            default:
            begin
                set_config(1'b1, decoder.swap, decoder.row_cells, decoder.string_mask,
                           decoder.expected_rows);
                send_word(1'b0, 64'h0000_0000_0000_FD64);
                send_word(1'b1, random_word());
            end
        endcase
    endtask

    task automatic test_requests_after_halt();
        send_word(1'b0, random_word());
        send_word(1'b1, random_word());
        repeat (10) send_word(1'($urandom_range(0, 1)), random_word());
    endtask

    always
    begin
        ready_wait = take_stalls ? $urandom_range(0, 19) : 0;
        if (ready_wait > 0)
        begin
            cells_ch.ready <= 1'b0;
            repeat (ready_wait) @(posedge clk);
        end
        cells_ch.ready <= 1'b1;
        do
            @(posedge clk);
        while (!(rst_n && cells_ch.valid === 1'b1));
    end

    always @(posedge clk)
    begin
        if (rst_n && cells_ch.valid === 1'b1 && cells_ch.ready === 1'b1)
        begin
            if (pending_cells.size() == 0)
            begin
                $error("cell result with none expected: status %0d, value %h",
                       cells_ch.status, cells_ch.cell_value);
                failures++;
            end
            else
            begin
                oldest = pending_cells.pop_front();
                if (cells_ch.status !== oldest.status)
                begin
                    $error("status: expected %0d, got %0d", oldest.status, cells_ch.status);
                    failures++;
                end
                if (cells_ch.cell_value !== oldest.value)
                begin
                    $error("cell_value: expected %h, got %h", oldest.value,
                           cells_ch.cell_value);
                    failures++;
                end
                if (cells_ch.cell_position !== oldest.position)
                begin
                    $error("cell_position: expected %0d, got %0d", oldest.position,
                           cells_ch.cell_position);
                    failures++;
                end
                if (cells_ch.row_number !== oldest.row)
                begin
                    $error("row_number: expected %0d, got %0d", oldest.row,
                           cells_ch.row_number);
                    failures++;
                end
                if (cells_ch.last !== oldest.last)
                begin
                    $error("last: expected %0d, got %0d", oldest.last, cells_ch.last);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((words_ch.valid === 1'b1 && words_ch.ready === 1'b1) ||
                (cells_ch.valid === 1'b1 && cells_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        words_ch.valid <= 1'b0;
        words_ch.kind <= 1'b0;
        words_ch.word <= 64'd0;
        cfg_we <= 1'b0;
        cfg_index <= sbcd_pkg::REG_COMPRESSED;
        cfg_data <= 64'd0;
        decoder = '{compressed: 1'b1, swap: 1'b0, row_cells: 7'd1, string_mask: 64'd0,
                    expected_rows: 31'd0, control: 64'd0, code_pos: 4'd8, awaiting: 1'b0,
                    cur_cell: 6'd0, rows: 31'd0, halted: 1'b0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_numeric_and_missing_codes();
        test_raw_and_space_codes();
        test_uncompressed_cells();
        test_mode_switch_with_pending_codes();
        test_random_streams();
        test_stop_condition();
        test_requests_after_halt();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sav_bytecode_cell_decoder_top.f =====
hw/rtl/sbcd_pkg.sv
hw/rtl/sbcd_if.sv
hw/rtl/sbcd_ctrl.sv
hw/rtl/sbcd_dp.sv
hw/rtl/sav_bytecode_cell_decoder_top.sv
hw/rtl/sbcd_chk.sv
bench/tb_sav_bytecode_cell_decoder_top.sv
